// ===== design/vertex_rotate_project_top_assert.svh =====
// assertion macros for the vertex rotate/project block
// no dependencies; included by the checker file
`ifndef VERTEX_ROTATE_PROJECT_TOP_ASSERT_SVH
`define VERTEX_ROTATE_PROJECT_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define VRP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define VRP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/vrp_pkg.sv =====
// shared types and constants for the vertex rotate/project block
// no dependencies; imported by every module of the block
package vrp_pkg;

    // screen size and focal terms
    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 768;
    localparam logic signed [13:0] HALF_W = 14'(SCREEN_WIDTH / 2);
    localparam logic signed [13:0] HALF_H = 14'(SCREEN_HEIGHT / 2);

    // widths
    localparam int CFG_W   = 32;
    localparam int COORD_W = 16;
    localparam int TRIG_W  = 18;
    localparam int ROT_W   = 40;
    localparam int SCL_W   = 48;
    localparam int DEN_W   = 49;
    localparam int NUM_W   = 64;
    localparam int QUO_W   = COORD_W + 1;
    localparam int TRY_W   = NUM_W + 2;
    localparam int FRAC_TRIG  = 14;
    localparam int FRAC_SCALE = 16;

    // pipeline depth: rotation 7, projection 3, divider, output register
    localparam int DIV_LAT     = QUO_W + 2;
    localparam int VRP_LATENCY = 10 + DIV_LAT + 1;

    // quarter-wave sine polynomial in q14
    localparam logic [15:0] POLY_A  = 16'd25736;
    localparam logic [15:0] POLY_B  = 16'd10512;
    localparam logic [15:0] POLY_C  = 16'd1160;
    localparam logic [14:0] Q14_ONE = 15'd16384;
    localparam logic [15:0] QUARTER = 16'h4000;
    localparam int TRIG_N = 6;

    // saturation limits
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [QUO_W-1:0] QUO_POS_LIM = QUO_W'((1 << (COORD_W - 1)) - 1);
    localparam logic [QUO_W-1:0] QUO_NEG_LIM = QUO_W'(1 << (COORD_W - 1));

    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [ROT_W-1:0]  t_rot;
    typedef logic signed [NUM_W-1:0]  t_num;
    typedef logic signed [DEN_W-1:0]  t_den;
    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [2:0] t_cfg_idx;

    // register indexes
    typedef enum logic [2:0] {
        REG_ANGLE_X     = 3'd0,
        REG_ANGLE_Y     = 3'd1,
        REG_ANGLE_Z     = 3'd2,
        REG_CAMERA_X    = 3'd3,
        REG_CAMERA_Y    = 3'd4,
        REG_CAMERA_Z    = 3'd5,
        REG_WORLD_SCALE = 3'd6
    } t_cfg_reg;

    // sine sequencer phases
    typedef enum logic [1:0] {
        PH_SQUARE,
        PH_INNER,
        PH_MID,
        PH_SCALE
    } t_trig_phase;

    typedef struct packed {
        t_trig sin_x;
        t_trig cos_x;
        t_trig sin_y;
        t_trig cos_y;
        t_trig sin_z;
        t_trig cos_z;
    } t_trig_set;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
    } t_vertex_in;

    typedef struct packed {
        t_coord screen_x;
        t_coord screen_y;
        logic   depth_zero;
        logic   clipped;
    } t_result;

endpackage

// ===== design/vrp_trig.sv =====
// sine/cosine sequencer: six q4.14 factors from three binary angles
// depends on vrp_pkg; one multiply step per phase, four phases per factor
module vrp_trig (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [15:0]         i_angle_x,
    input  logic [15:0]         i_angle_y,
    input  logic [15:0]         i_angle_z,
    output logic                o_busy,
    output vrp_pkg::t_trig_set  o_trig
);
    import vrp_pkg::*;

    t_trig_phase r_ph, n_ph;
    logic        r_run, n_run;
    logic [2:0]  r_idx, n_idx;
    logic [14:0] r_t, n_t;
    logic [15:0] r_t2, n_t2;
    logic [15:0] r_k, n_k;
    logic        r_neg, n_neg;
    t_trig       r_val [0:TRIG_N-1];

    logic [15:0] w_base;
    logic [15:0] w_ang;
    logic [14:0] w_t;
    logic [16:0] w_s;
    t_trig       w_val;
    logic        w_wr;

    // angle of the current entry: odd entries are cosines
    always_comb begin
        case (r_idx[2:1])
            2'd0:    w_base = i_angle_x;
            2'd1:    w_base = i_angle_y;
            default: w_base = i_angle_z;
        endcase
        w_ang = w_base + (r_idx[0] ? QUARTER : 16'd0);
        w_t   = w_ang[14] ? 15'(Q14_ONE - {1'b0, w_ang[13:0]}) : {1'b0, w_ang[13:0]};
        w_s   = 17'((32'(r_t) * 32'(r_k)) >> FRAC_TRIG);
        w_val = r_neg ? -t_trig'({1'b0, w_s}) : t_trig'({1'b0, w_s});
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph  <= PH_SQUARE;
            r_run <= 1'b0;
            r_idx <= '0;
        end else begin
            r_ph  <= n_ph;
            r_run <= n_run;
            r_idx <= n_idx;
        end
    end

    // next phase and one multiply per phase
    always_comb begin
        n_ph  = r_ph;
        n_run = r_run;
        n_idx = r_idx;
        n_t   = r_t;
        n_t2  = r_t2;
        n_k   = r_k;
        n_neg = r_neg;
        w_wr  = 1'b0;
        if (i_load) begin
            n_run = 1'b1;
            n_idx = '0;
            n_ph  = PH_SQUARE;
        end else if (r_run) begin
            case (r_ph)
                PH_SQUARE: begin
                    n_t   = w_t;
                    n_neg = w_ang[15];
                    n_t2  = 16'((32'(w_t) * 32'(w_t)) >> FRAC_TRIG);
                    n_ph  = PH_INNER;
                end
                PH_INNER: begin
                    n_k  = 16'(32'(POLY_B) - ((32'(POLY_C) * 32'(r_t2)) >> FRAC_TRIG));
                    n_ph = PH_MID;
                end
                PH_MID: begin
                    n_k  = 16'(32'(POLY_A) - ((32'(r_t2) * 32'(r_k)) >> FRAC_TRIG));
                    n_ph = PH_SCALE;
                end
                PH_SCALE: begin
                    w_wr = 1'b1;
                    n_ph = PH_SQUARE;
                    if (r_idx == 3'(TRIG_N - 1)) begin
                        n_run = 1'b0;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
                default: n_ph = PH_SQUARE;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_t   <= n_t;
        r_t2  <= n_t2;
        r_k   <= n_k;
        r_neg <= n_neg;
    end

    // factor table, reset to angle zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TRIG_N; i++) begin
                r_val[i] <= (i % 2 == 1) ? t_trig'({1'b0, Q14_ONE}) : '0;
            end
        end else if (w_wr) begin
            r_val[r_idx] <= w_val;
        end
    end

    assign o_busy       = r_run;
    assign o_trig.sin_x = r_val[0];
    assign o_trig.cos_x = r_val[1];
    assign o_trig.sin_y = r_val[2];
    assign o_trig.cos_y = r_val[3];
    assign o_trig.sin_z = r_val[4];
    assign o_trig.cos_z = r_val[5];

endmodule

// ===== design/vrp_div.sv =====
// pipelined restoring divider, one quotient bit per stage, saturating
// depends on vrp_pkg; sign stage, quotient stages and output register, one word per cycle
module vrp_div (
    input  logic           i_clk,
    input  vrp_pkg::t_num  i_num,
    input  vrp_pkg::t_den  i_den,
    output vrp_pkg::t_coord o_value,
    output logic           o_clip
);
    import vrp_pkg::*;

    logic [NUM_W-1:0] r_rem [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic             r_neg [0:QUO_W];
    logic             r_ovf [0:QUO_W];
    t_coord           r_value;
    logic             r_clip;

    logic [NUM_W-1:0] w_abs_num;
    logic [DEN_W-1:0] w_abs_den;
    logic [QUO_W-1:0] w_quo;

    // magnitudes
    assign w_abs_num = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign w_abs_den = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);
    assign w_quo     = r_quo[QUO_W];

    always_ff @(posedge i_clk) begin
        // sign and overflow stage
        r_rem[0] <= w_abs_num;
        r_den[0] <= w_abs_den;
        r_quo[0] <= '0;
        r_neg[0] <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
        r_ovf[0] <= TRY_W'(w_abs_num) >= {w_abs_den, {QUO_W{1'b0}}};

        // one quotient bit per stage, msb first
        for (int k = 1; k <= QUO_W; k++) begin
            if (TRY_W'(r_rem[k-1]) >= (TRY_W'(r_den[k-1]) << (QUO_W - k))) begin
                r_rem[k] <= NUM_W'(TRY_W'(r_rem[k-1]) - (TRY_W'(r_den[k-1]) << (QUO_W - k)));
                r_quo[k] <= {r_quo[k-1][QUO_W-2:0], 1'b1};
            end else begin
                r_rem[k] <= r_rem[k-1];
                r_quo[k] <= {r_quo[k-1][QUO_W-2:0], 1'b0};
            end
            r_den[k] <= r_den[k-1];
            r_neg[k] <= r_neg[k-1];
            r_ovf[k] <= r_ovf[k-1];
        end

        // sign and saturation
        if (r_ovf[QUO_W]) begin
            r_clip  <= 1'b1;
            r_value <= r_neg[QUO_W] ? COORD_MIN : COORD_MAX;
        end else if (!r_neg[QUO_W]) begin
            r_clip  <= w_quo > QUO_POS_LIM;
            r_value <= (w_quo > QUO_POS_LIM) ? COORD_MAX : t_coord'(w_quo[COORD_W-1:0]);
        end else begin
            r_clip  <= w_quo > QUO_NEG_LIM;
            r_value <= (w_quo > QUO_NEG_LIM) ? COORD_MIN : t_coord'(COORD_W'(~w_quo + 1'b1));
        end
    end

    assign o_value = r_value;
    assign o_clip  = r_clip;

endmodule

// ===== design/vertex_rotate_project_top.sv =====
// vertex rotate/project top: x-y-z rotation, scale, perspective divide
// depends on vrp_pkg, vrp_trig, vrp_div
// each accepted start gives an o_done strobe; one vertex per cycle while busy is low
// busy is high after an angle write while the trig sequencer
// rebuilds six factors at four multiply phases each
// synchronous active-low reset clears valids, presets config regs and factor table
module vertex_rotate_project_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  vrp_pkg::t_vertex_in  i_vertex,
    output logic                 o_done,
    output vrp_pkg::t_result     o_result,
    input  logic                 i_cfg_we,
    input  vrp_pkg::t_cfg_idx    i_cfg_idx,
    input  logic [vrp_pkg::CFG_W-1:0] i_cfg_data
);
    import vrp_pkg::*;

    // floored q4.14 product
    function automatic t_rot fmul(input t_rot v, input t_trig f);
        logic signed [ROT_W+TRIG_W-1:0] p;
        p = (ROT_W+TRIG_W)'(v) * (ROT_W+TRIG_W)'(f);
        return p[ROT_W+FRAC_TRIG-1:FRAC_TRIG];
    endfunction

    // clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input t_rot v);
        if (v[ROT_W-1:31] == '0 || v[ROT_W-1:31] == '1) begin
            return v[31:0];
        end
        return v[ROT_W-1] ? 32'sh80000000 : 32'sh7fffffff;
    endfunction

    // floored q16.16 scale
    function automatic logic signed [SCL_W-1:0] fscale(input logic signed [31:0] v,
                                                        input logic signed [31:0] s);
        logic signed [63:0] p;
        p = 64'(v) * 64'(s);
        return p[SCL_W+FRAC_SCALE-1:FRAC_SCALE];
    endfunction

    logic [15:0]        r_angle_x, r_angle_y, r_angle_z;
    logic signed [31:0] r_cam_x, r_cam_y, r_cam_z, r_world_scale;
    logic               w_trig_load;
    logic               w_trig_busy;
    t_trig_set          w_trig;
    logic               w_accept;
    logic [VRP_LATENCY-1:0] r_vld;

    t_rot r0_x, r0_y, r0_z;
    t_rot r1_x, r1_yc, r1_zs, r1_ys, r1_zc;
    t_rot r2_x, r2_y, r2_z;
    t_rot r3_y, r3_xc, r3_zs, r3_xs, r3_zc;
    t_rot r4_x, r4_y, r4_z;
    t_rot r5_z, r5_xc, r5_ys, r5_xs, r5_yc;
    logic signed [31:0]      r6_x, r6_y, r6_z;
    logic signed [SCL_W-1:0] r7_sx, r7_sy, r7_sz;
    t_den r8_d, r8_dx, r8_dy;
    t_num r9_nx, r9_ny;
    t_den r9_d;
    logic r9_dz;
    logic r_dz_dly [0:DIV_LAT-1];
    t_coord w_sx, w_sy;
    logic   w_clip_x, w_clip_y;
    t_result r_out;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_x     <= '0;
            r_angle_y     <= '0;
            r_angle_z     <= '0;
            r_cam_x       <= '0;
            r_cam_y       <= '0;
            r_cam_z       <= 32'sd655360;
            r_world_scale <= 32'sd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ANGLE_X:     r_angle_x     <= i_cfg_data[15:0];
                REG_ANGLE_Y:     r_angle_y     <= i_cfg_data[15:0];
                REG_ANGLE_Z:     r_angle_z     <= i_cfg_data[15:0];
                REG_CAMERA_X:    r_cam_x       <= i_cfg_data;
                REG_CAMERA_Y:    r_cam_y       <= i_cfg_data;
                REG_CAMERA_Z:    r_cam_z       <= i_cfg_data;
                REG_WORLD_SCALE: r_world_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // rebuild the factors after an angle write
    assign w_trig_load = i_cfg_we && (i_cfg_idx == REG_ANGLE_X ||
                                      i_cfg_idx == REG_ANGLE_Y ||
                                      i_cfg_idx == REG_ANGLE_Z);

    vrp_trig u_trig (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_trig_load),
        .i_angle_x (r_angle_x),
        .i_angle_y (r_angle_y),
        .i_angle_z (r_angle_z),
        .o_busy    (w_trig_busy),
        .o_trig    (w_trig)
    );

    assign busy     = w_trig_busy;
    assign w_accept = start && !w_trig_busy;

    // valid line alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[VRP_LATENCY-2:0], w_accept};
        end
    end

    // rotation stages: capture, then multiply and add for each axis
    always_ff @(posedge i_clk) begin
        r0_x <= ROT_W'(i_vertex.vertex_x);
        r0_y <= ROT_W'(i_vertex.vertex_y);
        r0_z <= ROT_W'(i_vertex.vertex_z);

        r1_x  <= r0_x;
        r1_yc <= fmul(r0_y, w_trig.cos_x);
        r1_zs <= fmul(r0_z, w_trig.sin_x);
        r1_ys <= fmul(r0_y, w_trig.sin_x);
        r1_zc <= fmul(r0_z, w_trig.cos_x);

        r2_x <= r1_x;
        r2_y <= r1_yc - r1_zs;
        r2_z <= r1_ys + r1_zc;

        r3_y  <= r2_y;
        r3_xc <= fmul(r2_x, w_trig.cos_y);
        r3_zs <= fmul(r2_z, w_trig.sin_y);
        r3_xs <= fmul(r2_x, w_trig.sin_y);
        r3_zc <= fmul(r2_z, w_trig.cos_y);

        r4_y <= r3_y;
        r4_x <= r3_xc + r3_zs;
        r4_z <= r3_zc - r3_xs;

        r5_z  <= r4_z;
        r5_xc <= fmul(r4_x, w_trig.cos_z);
        r5_ys <= fmul(r4_y, w_trig.sin_z);
        r5_xs <= fmul(r4_x, w_trig.sin_z);
        r5_yc <= fmul(r4_y, w_trig.cos_z);

        r6_x <= sat32(r5_xc - r5_ys);
        r6_y <= sat32(r5_xs + r5_yc);
        r6_z <= sat32(r5_z);
    end

    // projection stages: scale, camera offsets, numerators
    always_ff @(posedge i_clk) begin
        r7_sx <= fscale(r6_x, r_world_scale);
        r7_sy <= fscale(r6_y, r_world_scale);
        r7_sz <= fscale(r6_z, r_world_scale);

        r8_d  <= DEN_W'(r_cam_z) - DEN_W'(r7_sz);
        r8_dx <= DEN_W'(r7_sx) - DEN_W'(r_cam_x);
        r8_dy <= DEN_W'(r7_sy) - DEN_W'(r_cam_y);

        r9_nx <= NUM_W'(HALF_W) * NUM_W'(r8_dx) + NUM_W'(HALF_W) * NUM_W'(r8_d);
        r9_ny <= NUM_W'(HALF_W) * NUM_W'(r8_dy) + NUM_W'(HALF_H) * NUM_W'(r8_d);
        r9_d  <= r8_d;
        r9_dz <= r8_d == '0;
    end

    vrp_div u_div_x (
        .i_clk   (i_clk),
        .i_num   (r9_nx),
        .i_den   (r9_d),
        .o_value (w_sx),
        .o_clip  (w_clip_x)
    );

    vrp_div u_div_y (
        .i_clk   (i_clk),
        .i_num   (r9_ny),
        .i_den   (r9_d),
        .o_value (w_sy),
        .o_clip  (w_clip_y)
    );

    // zero-depth flag rides along with the dividers
    always_ff @(posedge i_clk) begin
        r_dz_dly[0] <= r9_dz;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_dz_dly[i] <= r_dz_dly[i-1];
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (r_dz_dly[DIV_LAT-1]) begin
            r_out.screen_x   <= '0;
            r_out.screen_y   <= '0;
            r_out.depth_zero <= 1'b1;
            r_out.clipped    <= 1'b0;
        end else begin
            r_out.screen_x   <= w_sx;
            r_out.screen_y   <= w_sy;
            r_out.depth_zero <= 1'b0;
            r_out.clipped    <= w_clip_x | w_clip_y;
        end
    end

    assign o_result = r_out;
    assign o_done   = r_vld[VRP_LATENCY-1];

endmodule

// ===== design/vrp_checker.sv =====
// port-level checker for vertex_rotate_project_top, bound below
// depends on vrp_pkg and vertex_rotate_project_top_assert.svh
`include "vertex_rotate_project_top_assert.svh"

module vrp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 i_cfg_we,
    input vrp_pkg::t_cfg_idx    i_cfg_idx,
    input logic                 o_done,
    input vrp_pkg::t_result     o_result
);
    import vrp_pkg::*;

    // every accepted vertex comes out after the fixed latency
    `VRP_ASSERT_IMP(a_word_out, i_clk, i_rst_n, start && !busy, ##VRP_LATENCY o_done, "word lost")

    // no strobe without a word accepted at the matching time
    `VRP_ASSERT_IMP(a_no_extra, i_clk, i_rst_n, o_done, $past(start && !busy, VRP_LATENCY), "extra word")

    // zero depth gives a clean zero word
    `VRP_ASSERT_IMP(a_depth_zero, i_clk, i_rst_n, o_done && o_result.depth_zero, o_result.screen_x == 16'sd0 && o_result.screen_y == 16'sd0 && !o_result.clipped, "bad zero-depth word")

    // clipped words carry a rail value
    `VRP_ASSERT_IMP(a_clip_rail, i_clk, i_rst_n, o_done && o_result.clipped, o_result.screen_x == COORD_MAX || o_result.screen_x == COORD_MIN || o_result.screen_y == COORD_MAX || o_result.screen_y == COORD_MIN, "clip without rail")

    // angle writes hold off new words while factors rebuild
    `VRP_ASSERT_NXT(a_angle_busy, i_clk, i_rst_n, i_cfg_we && (i_cfg_idx == REG_ANGLE_X || i_cfg_idx == REG_ANGLE_Y || i_cfg_idx == REG_ANGLE_Z), busy, "busy missing after angle write")

endmodule

bind vertex_rotate_project_top vrp_checker u_vrp_checker (.*);
